// ----- rtl/cartridge_bank_controller_macros.svh -----
// ----------------------------------------------------------------------------
// Cartridge bank controller assertion macros
// Shared property wrappers for the checker of the bank controller.
// ----------------------------------------------------------------------------
`ifndef CARTRIDGE_BANK_CONTROLLER_MACROS_SVH
`define CARTRIDGE_BANK_CONTROLLER_MACROS_SVH

// Same-cycle implication, switched off while reset is high.
`define CBC_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, also checked across reset.
`define CBC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/cbc_pkg.sv -----
// ----------------------------------------------------------------------------
// Cartridge bank controller package
// Request and mapper codes, register indexes, address boundaries and the
// request/response types of the shared remainder unit.
// ----------------------------------------------------------------------------
package cbc_pkg;

  // Remainder unit widths: dividend, divisor and step count.
  localparam int MOD_DW = 21;
  localparam int MOD_VW = 18;
  localparam int MOD_SW = 5;

  // ROM bank geometry.
  localparam int ROM_BANK_BYTES = 16384;
  localparam int ROM_BANK_SHIFT = 14;

  // Request codes.
  localparam logic [2:0] REQ_ROM_READ  = 3'd0;
  localparam logic [2:0] REQ_CONTROL   = 3'd1;
  localparam logic [2:0] REQ_RAM_READ  = 3'd2;
  localparam logic [2:0] REQ_RAM_WRITE = 3'd3;
  localparam logic [2:0] REQ_SAVE_DONE = 3'd4;

  // Mapper codes; any other code behaves as a plain cartridge.
  localparam logic [2:0] MAP_MBC1 = 3'd1;
  localparam logic [2:0] MAP_MBC2 = 3'd2;
  localparam logic [2:0] MAP_MBC3 = 3'd3;
  localparam logic [2:0] MAP_MBC5 = 3'd4;

  // Configuration register indexes.
  localparam logic [2:0] CFG_MAPPER_MODEL   = 3'd0;
  localparam logic [2:0] CFG_ROM_BANK_COUNT = 3'd1;
  localparam logic [2:0] CFG_RAM_BANK_COUNT = 3'd2;
  localparam logic [2:0] CFG_RAM_SIZE_BYTES = 3'd3;
  localparam logic [2:0] CFG_CLOCK_PRESENT  = 3'd4;
  localparam logic [2:0] CFG_SAVE_ENABLED   = 3'd5;

  // Control region boundaries.
  localparam logic [14:0] ADDR_ROM_LOW_SEL  = 15'h2000;
  localparam logic [14:0] ADDR_ROM_HIGH_SEL = 15'h3000;
  localparam logic [14:0] ADDR_RAM_SEL      = 15'h4000;
  localparam logic [14:0] ADDR_MODE_SEL     = 15'h6000;
  localparam logic [14:0] ADDR_ROM_SWITCHED = 15'h4000;

  // Work handed to the remainder unit.
  typedef struct packed {
    logic [MOD_DW-1:0] dividend;
    logic [MOD_SW-1:0] steps;
    logic [MOD_VW-1:0] divisor;
  } mod_req_t;

  // Result returned by the remainder unit.
  typedef struct packed {
    logic              done;
    logic [MOD_VW-1:0] remainder;
  } mod_rsp_t;

endpackage

// ----- rtl/cbc_ram.sv -----
// ----------------------------------------------------------------------------
// Generic single-port RAM
// One access per cycle, write or read, with a registered read port.
// ----------------------------------------------------------------------------
module cbc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 131072
) (
  input  logic                     clk,
  input  logic                     en,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Read data holds until the next read.
  always_ff @(posedge clk) begin
    if (en) begin
      if (we) begin
        mem[addr] <= wdata;
      end else begin
        rdata <= mem[addr];
      end
    end
  end

endmodule

// ----- rtl/cbc_mod.sv -----
// ----------------------------------------------------------------------------
// Shared remainder unit
// Restoring remainder, one dividend bit per cycle; the caller gives the
// number of significant dividend bits. A zero divisor returns the dividend, cut to the remainder width.
// ----------------------------------------------------------------------------
module cbc_mod (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  cbc_pkg::mod_req_t req,
  output cbc_pkg::mod_rsp_t rsp
);

  logic                         busy;
  logic                         done;
  logic [cbc_pkg::MOD_SW-1:0]   count;
  logic [cbc_pkg::MOD_DW-1:0]   shifter;
  logic [cbc_pkg::MOD_VW-1:0]   divisor_q;
  logic [cbc_pkg::MOD_VW-1:0]   rem;
  logic [cbc_pkg::MOD_VW:0]     trial;
  logic                         fits;

  // Bring down the next dividend bit and test against the divisor.
  assign trial = {rem, shifter[cbc_pkg::MOD_DW-1]};
  assign fits  = trial >= {1'b0, divisor_q};

  // Step counter and completion pulse.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      count <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        count <= req.steps;
      end else if (busy) begin
        count <= count - 1'b1;
        if (count == cbc_pkg::MOD_SW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Datapath: the dividend is left-aligned so that only its live bits are stepped.
  always_ff @(posedge clk) begin
    if (start) begin
      shifter   <= req.dividend << (cbc_pkg::MOD_SW'(cbc_pkg::MOD_DW) - req.steps);
      divisor_q <= req.divisor;
      rem       <= '0;
    end else if (busy) begin
      shifter <= shifter << 1;
      rem     <= fits ? cbc_pkg::MOD_VW'(trial - {1'b0, divisor_q})
                      : trial[cbc_pkg::MOD_VW-1:0];
    end
  end

  assign rsp.done      = done;
  assign rsp.remainder = rem;

endmodule

// ----- rtl/cartridge_bank_controller.sv -----
// ----------------------------------------------------------------------------
// Cartridge bank controller
// Bank translation for plain, MBC1, MBC2, MBC3 and MBC5 cartridges, with the
// cartridge RAM held in an internal memory. After reset the RAM is cleared
// one byte a cycle, and no request is taken until that pass ends;
// configuration writes are taken throughout. Requests are handled one at
// a time by a small sequencer: decode, an optional bank remainder,
// location, an optional reduction of the RAM offset, the memory access for
// RAM requests and completion. Each remainder runs on one shared restoring
// unit at one cycle per dividend bit, first for bank and size reductions and
// again for each RAM access when RAM_TOTAL_BYTES is not a power of two and
// the mapper is not MBC2. The next request is taken while the previous
// result waits in the output register.
// ----------------------------------------------------------------------------
module cartridge_bank_controller #(
  parameter int RAM_TOTAL_BYTES = 131072
) (
  input  logic        clk,
  input  logic        rst,
  // Configuration write port
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [17:0] cfg_data,
  // Request channel
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  req_type,
  input  logic [14:0] addr,
  input  logic [7:0]  data,
  // Result channel
  output logic        out_valid,
  input  logic        out_ready,
  output logic [22:0] rom_offset,
  output logic [7:0]  read_data,
  output logic        clock_access,
  output logic [7:0]  clock_register,
  output logic [7:0]  clock_write_data,
  output logic        clock_latch,
  output logic        clock_latch_value,
  output logic        save_request,
  output logic        was_dirty
);

  localparam int AW = $clog2(RAM_TOTAL_BYTES);
  localparam bit TOTAL_POW2 = ((RAM_TOTAL_BYTES & (RAM_TOTAL_BYTES - 1)) == 0);
  localparam logic [AW-1:0] LAST_ADDR = AW'(RAM_TOTAL_BYTES - 1);

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_DECODE,
    ST_MOD_A,
    ST_LOCATE,
    ST_MOD_B,
    ST_ACCESS,
    ST_FINISH
  } state_t;

  typedef enum logic [1:0] {
    KIND_NONE,
    KIND_RAM,
    KIND_CLOCK
  } ram_kind_t;

  // Configuration registers
  logic [2:0]  mapper_model;
  logic [9:0]  rom_bank_count;
  logic [4:0]  ram_bank_count;
  logic [17:0] ram_size_bytes;
  logic        clock_present;
  logic        save_enabled;

  // Mapper state
  logic [8:0]  rom_bank;
  logic [7:0]  ram_bank;
  logic        ram_locked;
  logic        ram_mode;
  logic        dirty;
  logic [8:0]  rom_bank_next;
  logic [7:0]  ram_bank_next;
  logic        ram_locked_next;
  logic        ram_mode_next;
  logic        dirty_next;

  // Sequencer and captured request
  state_t      state;
  logic [AW-1:0] clr_addr;
  logic [2:0]  req_q;
  logic [14:0] addr_q;
  logic [7:0]  data_q;
  logic [cbc_pkg::MOD_VW-1:0] mres;
  logic [AW-1:0] off;

  // Decode
  logic        mbc1, mbc2, mbc3, mbc5, any_mapper;
  logic [12:0] ra;
  logic        ram_op;
  ram_kind_t   kind;
  logic [cbc_pkg::MOD_DW-1:0] o_full;
  logic        direct_ok;
  logic [6:0]  mbc1_masked;
  logic [6:0]  mbc1_bank;
  logic [8:0]  rom_sel_bank;
  logic [22:0] rom_off;
  logic        need_mod_a;
  cbc_pkg::mod_req_t mod_a;
  cbc_pkg::mod_req_t mod_b;
  cbc_pkg::mod_req_t mod_req;
  cbc_pkg::mod_rsp_t mod_rsp;
  logic        mod_start;
  logic        finish_go;

  // Memory port
  logic          mem_en;
  logic          mem_we;
  logic [AW-1:0] mem_addr;
  logic [7:0]    mem_wdata;
  logic [7:0]    mem_rdata;

  // Result values
  logic [22:0] res_rom_offset;
  logic [7:0]  res_read_data;
  logic        res_clock_access;
  logic [7:0]  res_clock_register;
  logic [7:0]  res_clock_write_data;
  logic        res_clock_latch;
  logic        res_clock_latch_value;
  logic        res_save_request;
  logic        res_was_dirty;

  // Configuration registers take writes at any time.
  always_ff @(posedge clk) begin
    if (rst) begin
      mapper_model   <= '0;
      rom_bank_count <= 10'd2;
      ram_bank_count <= '0;
      ram_size_bytes <= '0;
      clock_present  <= 1'b0;
      save_enabled   <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        cbc_pkg::CFG_MAPPER_MODEL:   mapper_model   <= cfg_data[2:0];
        cbc_pkg::CFG_ROM_BANK_COUNT: rom_bank_count <= cfg_data[9:0];
        cbc_pkg::CFG_RAM_BANK_COUNT: ram_bank_count <= cfg_data[4:0];
        cbc_pkg::CFG_RAM_SIZE_BYTES: ram_size_bytes <= cfg_data;
        cbc_pkg::CFG_CLOCK_PRESENT:  clock_present  <= cfg_data[0];
        cbc_pkg::CFG_SAVE_ENABLED:   save_enabled   <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Mapper flags; unknown codes leave all of them low.
  assign mbc1       = (mapper_model == cbc_pkg::MAP_MBC1);
  assign mbc2       = (mapper_model == cbc_pkg::MAP_MBC2);
  assign mbc3       = (mapper_model == cbc_pkg::MAP_MBC3);
  assign mbc5       = (mapper_model == cbc_pkg::MAP_MBC5);
  assign any_mapper = mbc1 | mbc2 | mbc3 | mbc5;

  assign ra     = addr_q[12:0];
  assign ram_op = (req_q == cbc_pkg::REQ_RAM_READ) ||
                  ((req_q == cbc_pkg::REQ_RAM_WRITE) && !ram_locked);

  // MBC1 switchable bank before the ROM size reduction.
  assign mbc1_masked = rom_bank[6:0] & (ram_mode ? 7'h1f : 7'h7f);
  assign mbc1_bank   = (mbc1_masked == 7'd0) ? 7'd1 : mbc1_masked;

  // RAM location: kind of target and unreduced byte offset.
  always_comb begin
    kind   = KIND_NONE;
    o_full = '0;
    if (mbc1) begin
      if (ram_bank_count != 5'd0) begin
        kind = KIND_RAM;
        if (ram_bank_count == 5'd1) begin
          o_full = cbc_pkg::MOD_DW'(mres[12:0]);
        end else begin
          o_full = cbc_pkg::MOD_DW'({(ram_mode ? ram_bank[1:0] : 2'b00), ra});
        end
      end
    end else if (mbc2) begin
      kind   = KIND_RAM;
      o_full = cbc_pkg::MOD_DW'(ra[8:0]);
    end else if (mbc3) begin
      if (ram_bank > 8'd3) begin
        kind = KIND_CLOCK;
      end else if (ram_bank_count != 5'd0) begin
        kind   = KIND_RAM;
        o_full = cbc_pkg::MOD_DW'({mres[1:0], ra});
      end
    end else if (mbc5) begin
      if (ram_bank_count != 5'd0) begin
        kind   = KIND_RAM;
        o_full = {ram_bank, ra};
      end
    end
  end

  // The final reduction is a plain mask when the RAM size is a power of two or the mapper is MBC2.
  assign direct_ok = TOTAL_POW2 || mbc2;

  // First remainder: a bank number or the mirrored partial bank.
  always_comb begin
    need_mod_a = 1'b0;
    mod_a      = '0;
    unique case (req_q) inside
      cbc_pkg::REQ_ROM_READ: begin
        if (addr_q >= cbc_pkg::ADDR_ROM_SWITCHED) begin
          if (mbc1) begin
            need_mod_a     = 1'b1;
            mod_a.dividend = cbc_pkg::MOD_DW'(mbc1_bank);
            mod_a.steps    = cbc_pkg::MOD_SW'(7);
            mod_a.divisor  = cbc_pkg::MOD_VW'(rom_bank_count);
          end else if (mbc5) begin
            need_mod_a     = 1'b1;
            mod_a.dividend = cbc_pkg::MOD_DW'(rom_bank);
            mod_a.steps    = cbc_pkg::MOD_SW'(9);
            mod_a.divisor  = cbc_pkg::MOD_VW'(rom_bank_count);
          end
        end
      end
      cbc_pkg::REQ_CONTROL: begin
        if (mbc1 && addr_q >= cbc_pkg::ADDR_RAM_SEL && addr_q < cbc_pkg::ADDR_MODE_SEL &&
            ram_bank_count != 5'd0) begin
          need_mod_a     = 1'b1;
          mod_a.dividend = cbc_pkg::MOD_DW'(data_q[1:0]);
          mod_a.steps    = cbc_pkg::MOD_SW'(2);
          mod_a.divisor  = cbc_pkg::MOD_VW'(ram_bank_count);
        end else if (mbc3 && addr_q >= cbc_pkg::ADDR_ROM_LOW_SEL &&
                     addr_q < cbc_pkg::ADDR_RAM_SEL) begin
          need_mod_a     = 1'b1;
          mod_a.dividend = cbc_pkg::MOD_DW'(data_q[6:0]);
          mod_a.steps    = cbc_pkg::MOD_SW'(7);
          mod_a.divisor  = cbc_pkg::MOD_VW'(rom_bank_count);
        end else if (mbc5 && addr_q >= cbc_pkg::ADDR_RAM_SEL &&
                     addr_q < cbc_pkg::ADDR_MODE_SEL && ram_bank_count != 5'd0) begin
          need_mod_a     = 1'b1;
          mod_a.dividend = cbc_pkg::MOD_DW'(data_q[3:0]);
          mod_a.steps    = cbc_pkg::MOD_SW'(4);
          mod_a.divisor  = cbc_pkg::MOD_VW'(ram_bank_count);
        end
      end
      cbc_pkg::REQ_RAM_READ, cbc_pkg::REQ_RAM_WRITE: begin
        if (ram_op && mbc1 && ram_bank_count == 5'd1) begin
          need_mod_a     = 1'b1;
          mod_a.dividend = cbc_pkg::MOD_DW'(ra);
          mod_a.steps    = cbc_pkg::MOD_SW'(13);
          mod_a.divisor  = ram_size_bytes;
        end else if (ram_op && mbc3 && kind == KIND_RAM) begin
          need_mod_a     = 1'b1;
          mod_a.dividend = cbc_pkg::MOD_DW'(ram_bank[1:0]);
          mod_a.steps    = cbc_pkg::MOD_SW'(2);
          mod_a.divisor  = cbc_pkg::MOD_VW'(ram_bank_count);
        end
      end
      default: ;
    endcase
  end

  // Second remainder: offset reduced to the RAM size.
  assign mod_b.dividend = o_full;
  assign mod_b.steps    = cbc_pkg::MOD_SW'(cbc_pkg::MOD_DW);
  assign mod_b.divisor  = cbc_pkg::MOD_VW'(RAM_TOTAL_BYTES);

  assign mod_start = ((state == ST_DECODE) && need_mod_a) ||
                     ((state == ST_LOCATE) && ram_op && (kind == KIND_RAM) && !direct_ok);
  assign mod_req   = (state == ST_LOCATE) ? mod_b : mod_a;

  cbc_mod u_mod (
    .clk   (clk),
    .rst   (rst),
    .start (mod_start),
    .req   (mod_req),
    .rsp   (mod_rsp)
  );

  // ROM offset; the reduced bank sits in the remainder register for MBC1 and MBC5.
  assign rom_sel_bank = (mbc1 || mbc5) ? mres[8:0] : rom_bank;
  assign rom_off = (addr_q < cbc_pkg::ADDR_ROM_SWITCHED || !any_mapper)
                 ? 23'(addr_q)
                 : 23'(addr_q) + (23'(rom_sel_bank) << cbc_pkg::ROM_BANK_SHIFT)
                   - 23'(cbc_pkg::ROM_BANK_BYTES);

  // Result fields and next mapper state for the request in hand.
  always_comb begin
    res_rom_offset        = '0;
    res_read_data         = '0;
    res_clock_access      = 1'b0;
    res_clock_register    = '0;
    res_clock_write_data  = '0;
    res_clock_latch       = 1'b0;
    res_clock_latch_value = 1'b0;
    res_save_request      = 1'b0;
    res_was_dirty         = 1'b0;
    rom_bank_next         = rom_bank;
    ram_bank_next         = ram_bank;
    ram_locked_next       = ram_locked;
    ram_mode_next         = ram_mode;
    dirty_next            = dirty;
    unique case (req_q) inside
      cbc_pkg::REQ_ROM_READ: begin
        res_rom_offset = rom_off;
      end
      cbc_pkg::REQ_CONTROL: begin
        if (any_mapper && addr_q < cbc_pkg::ADDR_ROM_LOW_SEL) begin
          ram_locked_next = (data_q[3:0] != 4'ha);
        end else if (mbc1) begin
          if (addr_q < cbc_pkg::ADDR_RAM_SEL) begin
            rom_bank_next = {rom_bank[8:5], data_q[4:0]};
          end else if (addr_q < cbc_pkg::ADDR_MODE_SEL) begin
            rom_bank_next = {2'b00, data_q[1:0], rom_bank[4:0]};
            if (ram_bank_count != 5'd0) begin
              ram_bank_next = 8'(mres[1:0]);
            end
          end else begin
            ram_mode_next = data_q[0];
          end
        end else if (mbc2) begin
          if (addr_q < cbc_pkg::ADDR_RAM_SEL) begin
            rom_bank_next = (data_q[3:0] == 4'd0) ? 9'd1 : 9'(data_q[3:0]);
          end
        end else if (mbc3) begin
          if (addr_q < cbc_pkg::ADDR_RAM_SEL) begin
            rom_bank_next = (mres[6:0] == 7'd0) ? 9'd1 : 9'(mres[6:0]);
          end else if (addr_q < cbc_pkg::ADDR_MODE_SEL) begin
            ram_bank_next = data_q;
          end else if (clock_present) begin
            res_clock_latch       = 1'b1;
            res_clock_latch_value = (data_q == 8'd1);
          end
        end else if (mbc5) begin
          if (addr_q < cbc_pkg::ADDR_ROM_HIGH_SEL) begin
            rom_bank_next = {rom_bank[8], data_q};
          end else if (addr_q < cbc_pkg::ADDR_RAM_SEL) begin
            rom_bank_next = {data_q[0], rom_bank[7:0]};
          end else if (addr_q < cbc_pkg::ADDR_MODE_SEL && ram_bank_count != 5'd0) begin
            ram_bank_next = 8'(mres[3:0]);
          end
        end
      end
      cbc_pkg::REQ_RAM_READ: begin
        res_read_data = (kind == KIND_RAM) ? mem_rdata : 8'hff;
        if (kind == KIND_CLOCK && clock_present && !ram_locked) begin
          res_clock_access   = 1'b1;
          res_clock_register = ram_bank;
        end
      end
      cbc_pkg::REQ_RAM_WRITE: begin
        if (!ram_locked && kind != KIND_NONE) begin
          if (kind == KIND_CLOCK && clock_present) begin
            res_clock_access     = 1'b1;
            res_clock_register   = ram_bank;
            res_clock_write_data = data_q;
          end
          if (save_enabled) begin
            dirty_next       = 1'b1;
            res_save_request = 1'b1;
          end
        end
      end
      cbc_pkg::REQ_SAVE_DONE: begin
        res_was_dirty = dirty;
        dirty_next    = 1'b0;
      end
      default: ;
    endcase
  end

  // Cartridge RAM: the clearing pass and the single request access share one port.
  assign mem_en    = (state == ST_CLEAR) || (state == ST_ACCESS);
  assign mem_we    = (state == ST_CLEAR) ||
                     ((state == ST_ACCESS) && (req_q == cbc_pkg::REQ_RAM_WRITE));
  assign mem_addr  = (state == ST_CLEAR) ? clr_addr : off;
  assign mem_wdata = (state == ST_CLEAR) ? 8'h00 : (mbc2 ? (data_q | 8'hf0) : data_q);

  cbc_ram #(
    .WIDTH (8),
    .DEPTH (RAM_TOTAL_BYTES)
  ) u_cart_ram (
    .clk   (clk),
    .en    (mem_en),
    .we    (mem_we),
    .addr  (mem_addr),
    .wdata (mem_wdata),
    .rdata (mem_rdata)
  );

  assign in_ready  = (state == ST_IDLE);
  assign finish_go = (state == ST_FINISH) && (!out_valid || out_ready);

  // Sequencer, mapper state and the output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_CLEAR;
      clr_addr   <= '0;
      out_valid  <= 1'b0;
      rom_bank   <= 9'd1;
      ram_bank   <= '0;
      ram_locked <= 1'b1;
      ram_mode   <= 1'b0;
      dirty      <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_CLEAR: begin
          clr_addr <= clr_addr + 1'b1;
          if (clr_addr == LAST_ADDR) begin
            state <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (in_valid) begin
            req_q  <= req_type;
            addr_q <= addr;
            data_q <= data;
            state  <= ST_DECODE;
          end
        end
        ST_DECODE: begin
          state <= need_mod_a ? ST_MOD_A : ST_LOCATE;
        end
        ST_MOD_A: begin
          if (mod_rsp.done) begin
            mres  <= mod_rsp.remainder;
            state <= ST_LOCATE;
          end
        end
        ST_LOCATE: begin
          if (ram_op && kind == KIND_RAM) begin
            if (direct_ok) begin
              off   <= o_full[AW-1:0];
              state <= ST_ACCESS;
            end else begin
              state <= ST_MOD_B;
            end
          end else begin
            state <= ST_FINISH;
          end
        end
        ST_MOD_B: begin
          if (mod_rsp.done) begin
            off   <= mod_rsp.remainder[AW-1:0];
            state <= ST_ACCESS;
          end
        end
        ST_ACCESS: begin
          state <= ST_FINISH;
        end
        ST_FINISH: begin
          if (finish_go) begin
            out_valid         <= 1'b1;
            rom_offset        <= res_rom_offset;
            read_data         <= res_read_data;
            clock_access      <= res_clock_access;
            clock_register    <= res_clock_register;
            clock_write_data  <= res_clock_write_data;
            clock_latch       <= res_clock_latch;
            clock_latch_value <= res_clock_latch_value;
            save_request      <= res_save_request;
            was_dirty         <= res_was_dirty;
            rom_bank          <= rom_bank_next;
            ram_bank          <= ram_bank_next;
            ram_locked        <= ram_locked_next;
            ram_mode          <= ram_mode_next;
            dirty             <= dirty_next;
            state             <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

// ----- rtl/cbc_checker.sv -----
// ----------------------------------------------------------------------------
// Cartridge bank controller checker
// Port-level properties of the result channel, bound to the top level.
// ----------------------------------------------------------------------------
`include "cartridge_bank_controller_macros.svh"

module cbc_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [22:0] rom_offset,
  input logic [7:0]  read_data,
  input logic        clock_access,
  input logic [7:0]  clock_register,
  input logic [7:0]  clock_write_data,
  input logic        clock_latch,
  input logic        clock_latch_value,
  input logic        save_request,
  input logic        was_dirty
);

  // The RAM clearing pass follows every reset, so no request is taken at once.
  `CBC_ASSERT_NEXT(a_clear_after_reset, rst, !in_ready, "request taken during RAM clear")

  // A latch value is only reported together with a latch command.
  `CBC_ASSERT_NOW(a_latch_value, out_valid && !clock_latch, !clock_latch_value, "stray latch value")

  // Clock register fields stay zero unless a clock register is addressed.
  `CBC_ASSERT_NOW(a_clock_fields, out_valid && !clock_access, clock_register == 8'd0 && clock_write_data == 8'd0, "clock fields without clock access")

  // A save request only comes from a RAM write, which carries no ROM offset, dirty status or latch.
  `CBC_ASSERT_NOW(a_save_alone, out_valid && save_request, rom_offset == 23'd0 && !was_dirty && !clock_latch, "save request mixed with other results")

  // A result that is not taken stays in place.
  `CBC_ASSERT_NEXT(a_result_hold, !rst && out_valid && !out_ready, out_valid && $stable(rom_offset) && $stable(read_data), "result dropped or changed while stalled")

endmodule

bind cartridge_bank_controller cbc_checker u_cbc_checker (.*);

// ----- dv/tb.sv -----
// ----------------------------------------------------------------------------
// Cartridge bank controller testbench
// Drives bus accesses and configuration writes into the bank controller and
// predicts every result with a behavioural model of the mappers. The model
// keeps its own bank registers, RAM enable, banking mode, dirty flag and copy
// of the cartridge RAM. Results are compared field by field, in order. The
// run covers directed corner cases, random configurations with random
// traffic, a long receiver hold-off and a final stretch without idling.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;
  import cbc_pkg::*;

  // Codes and sizes that the package does not name.
  localparam logic [2:0] MAP_NONE         = 3'd0;
  localparam logic [2:0] MAP_UNKNOWN      = 3'd6;
  localparam logic [2:0] REQ_UNKNOWN      = 3'd7;
  localparam logic [3:0] RAM_ENABLE_KEY   = 4'hA;
  localparam logic [7:0] READ_ABSENT      = 8'hFF;
  localparam logic [7:0] MBC2_HIGH_NIBBLE = 8'hF0;
  localparam logic [7:0] CLOCK_SELECT_MAX = 8'd3;
  localparam int         RAM_BANK_BYTES   = 8192;
  localparam int         RAM_BYTES        = 131072;
  localparam int         MBC2_NIBBLES     = 512;

  typedef enum logic [1:0] {LOC_NONE, LOC_RAM, LOC_CLOCK} ram_target_e;

  typedef struct packed {
    logic [22:0] rom_offset;
    logic [7:0]  read_data;
    logic        clock_access;
    logic [7:0]  clock_register;
    logic [7:0]  clock_write_data;
    logic        clock_latch;
    logic        clock_latch_value;
    logic        save_request;
    logic        was_dirty;
  } bank_result_t;

  // Block ports; the inputs are at known values from time zero.
  logic        clk               = 1'b0;
  logic        rst               = 1'b1;
  logic        cfg_we            = 1'b0;
  logic [2:0]  cfg_index         = '0;
  logic [17:0] cfg_data          = '0;
  logic        in_valid          = 1'b0;
  logic        in_ready;
  logic [2:0]  req_type          = '0;
  logic [14:0] addr              = '0;
  logic [7:0]  data              = '0;
  logic        out_valid;
  logic        out_ready         = 1'b0;
  logic [22:0] rom_offset;
  logic [7:0]  read_data;
  logic        clock_access;
  logic [7:0]  clock_register;
  logic [7:0]  clock_write_data;
  logic        clock_latch;
  logic        clock_latch_value;
  logic        save_request;
  logic        was_dirty;

  // Shadow configuration, at its reset values.
  logic [2:0]  cfg_mapper    = MAP_NONE;
  logic [9:0]  cfg_rom_banks = 10'd2;
  logic [4:0]  cfg_ram_banks = 5'd0;
  logic [17:0] cfg_ram_size  = 18'd0;
  logic        cfg_clock     = 1'b0;
  logic        cfg_save      = 1'b0;

  // Shadow mapper state, at its reset values.
  logic [8:0]  rom_bank   = 9'd1;
  logic [7:0]  ram_bank   = 8'd0;
  logic        ram_locked = 1'b1;
  logic        ram_mode   = 1'b0;
  logic        dirty      = 1'b0;
  logic [7:0]  shadow_ram [RAM_BYTES];

  bank_result_t expected_results [$];
  int           mismatches  = 0;
  bit           idling_on   = 1'b0;
  int           stall_left  = 0;
  int           hold_cycles = 0;

  cartridge_bank_controller i_dut (
    .clk               (clk),
    .rst               (rst),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .req_type          (req_type),
    .addr              (addr),
    .data              (data),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .rom_offset        (rom_offset),
    .read_data         (read_data),
    .clock_access      (clock_access),
    .clock_register    (clock_register),
    .clock_write_data  (clock_write_data),
    .clock_latch       (clock_latch),
    .clock_latch_value (clock_latch_value),
    .save_request      (save_request),
    .was_dirty         (was_dirty)
  );

  // 12 ns clock.
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Overall time limit, several times the slowest legal run.
  initial begin
    #15_000_000;
    $display("Verification failed");
    $finish;
  end

  // ------------------------------------------------------------------------
  // Mapper model
  // ------------------------------------------------------------------------

  // Bank reduction by the declared ROM bank count; a count of zero skips it.
  function automatic logic [31:0] reduce_rom_bank(logic [31:0] b);
    return (cfg_rom_banks != 0) ? b % cfg_rom_banks : b;
  endfunction

  // ROM-region offset translation; arithmetic wraps at 32 bits.
  function automatic logic [22:0] translate_rom(logic [14:0] a);
    logic [31:0] bank;
    logic [31:0] ofs;
    ofs = {17'd0, a};
    if (a < ADDR_ROM_SWITCHED) return ofs[22:0];
    case (cfg_mapper)
      MAP_MBC1: begin
        bank = {23'd0, rom_bank} % (ram_mode ? 32'd32 : 32'd128);
        if (bank == 0) bank = 32'd1;
        bank = reduce_rom_bank(bank);
        ofs  = ofs + (bank - 32'd1) * ROM_BANK_BYTES;
      end
      MAP_MBC2, MAP_MBC3: begin
        ofs = ofs + ({23'd0, rom_bank} - 32'd1) * ROM_BANK_BYTES;
      end
      MAP_MBC5: begin
        ofs = ofs - ROM_BANK_BYTES + reduce_rom_bank({23'd0, rom_bank}) * ROM_BANK_BYTES;
      end
      default: ;
    endcase
    return ofs[22:0];
  endfunction

  // Control writes: RAM enable, bank selects, banking mode and clock latch.
  function automatic void apply_control(logic [14:0] a, logic [7:0] v,
                                        inout bank_result_t r);
    if (cfg_mapper < MAP_MBC1 || cfg_mapper > MAP_MBC5) return;
    if (a < ADDR_ROM_LOW_SEL) begin
      ram_locked = (v[3:0] != RAM_ENABLE_KEY);
      return;
    end
    case (cfg_mapper)
      MAP_MBC1: begin
        if (a < ADDR_RAM_SEL) begin
          rom_bank[4:0] = v[4:0];
        end else if (a < ADDR_MODE_SEL) begin
          rom_bank = {2'b00, v[1:0], rom_bank[4:0]};
          if (cfg_ram_banks != 0) ram_bank = v[1:0] % cfg_ram_banks;
        end else begin
          ram_mode = v[0];
        end
      end
      MAP_MBC2: begin
        if (a < ADDR_RAM_SEL) begin
          rom_bank = {5'd0, v[3:0]};
          if (rom_bank == 0) rom_bank = 9'd1;
        end
      end
      MAP_MBC3: begin
        if (a < ADDR_RAM_SEL) begin
          rom_bank = 9'(reduce_rom_bank({25'd0, v[6:0]}));
          if (rom_bank == 0) rom_bank = 9'd1;
        end else if (a < ADDR_MODE_SEL) begin
          ram_bank = v;
        end else if (cfg_clock) begin
          r.clock_latch       = 1'b1;
          r.clock_latch_value = (v == 8'd1);
        end
      end
      default: begin
        if (a < ADDR_ROM_HIGH_SEL) rom_bank[7:0] = v;
        else if (a < ADDR_RAM_SEL) rom_bank[8] = v[0];
        else if (a < ADDR_MODE_SEL && cfg_ram_banks != 0) ram_bank = v[3:0] % cfg_ram_banks;
      end
    endcase
  endfunction

  // Works out where a RAM access lands: nowhere, the RAM or a clock register.
  function automatic ram_target_e locate_ram(logic [12:0] a, output logic [16:0] off);
    logic [31:0] o;
    off = '0;
    case (cfg_mapper)
      MAP_MBC1: begin
        if (cfg_ram_banks == 0) return LOC_NONE;
        if (cfg_ram_banks == 1)
          o = (cfg_ram_size != 0) ? a % cfg_ram_size : {19'd0, a};
        else
          o = (ram_mode ? {30'd0, ram_bank[1:0]} : 32'd0) * RAM_BANK_BYTES + a;
      end
      MAP_MBC2: o = a % MBC2_NIBBLES;
      MAP_MBC3: begin
        if (ram_bank > CLOCK_SELECT_MAX) return LOC_CLOCK;
        if (cfg_ram_banks == 0) return LOC_NONE;
        o = (ram_bank % cfg_ram_banks) * RAM_BANK_BYTES + a;
      end
      MAP_MBC5: begin
        if (cfg_ram_banks == 0) return LOC_NONE;
        o = ram_bank * RAM_BANK_BYTES + a;
      end
      default: return LOC_NONE;
    endcase
    off = o[16:0];
    return LOC_RAM;
  endfunction

  // Expected result of one bus access; updates the shadow state.
  function automatic bank_result_t predict_access(logic [2:0] kind, logic [14:0] a,
                                                  logic [7:0] v);
    bank_result_t r;
    ram_target_e  target;
    logic [16:0]  off;
    r = '0;
    case (kind)
      REQ_ROM_READ: r.rom_offset = translate_rom(a);
      REQ_CONTROL:  apply_control(a, v, r);
      REQ_RAM_READ: begin
        r.read_data = READ_ABSENT;
        target = locate_ram(a[12:0], off);
        if (target == LOC_RAM) begin
          r.read_data = shadow_ram[off];
        end else if (target == LOC_CLOCK && cfg_clock && !ram_locked) begin
          r.clock_access   = 1'b1;
          r.clock_register = ram_bank;
        end
      end
      REQ_RAM_WRITE: begin
        if (!ram_locked) begin
          target = locate_ram(a[12:0], off);
          if (target != LOC_NONE) begin
            if (target == LOC_RAM) begin
              shadow_ram[off] = (cfg_mapper == MAP_MBC2) ? (v | MBC2_HIGH_NIBBLE) : v;
            end else if (cfg_clock) begin
              r.clock_access     = 1'b1;
              r.clock_register   = ram_bank;
              r.clock_write_data = v;
            end
            // A clock select without a clock still marks the RAM dirty.
            if (cfg_save) begin
              dirty          = 1'b1;
              r.save_request = 1'b1;
            end
          end
        end
      end
      REQ_SAVE_DONE: begin
        r.was_dirty = dirty;
        dirty       = 1'b0;
      end
      default: ;
    endcase
    return r;
  endfunction

  // ------------------------------------------------------------------------
  // Reporting and result checking
  // ------------------------------------------------------------------------

  // Only the first hundred mismatches are printed to keep the log readable.
  task automatic note_mismatch(string what, logic [31:0] got, logic [31:0] want);
    mismatches++;
    if (mismatches <= 100)
      $display("%0t ns: mismatch on %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
  endtask

  task automatic check_field(string what, logic [31:0] got, logic [31:0] want);
    if (got !== want) note_mismatch(what, got, want);
  endtask

  // Each result transfer is compared with the oldest expectation.
  always @(posedge clk) begin
    bank_result_t want;
    if (!rst && out_valid && out_ready) begin
      if (expected_results.size() == 0) begin
        note_mismatch("result with nothing expected", 32'(rom_offset), 32'd0);
      end else begin
        want = expected_results.pop_front();
        check_field("rom_offset", 32'(rom_offset), 32'(want.rom_offset));
        check_field("read_data", 32'(read_data), 32'(want.read_data));
        check_field("clock_access", 32'(clock_access), 32'(want.clock_access));
        check_field("clock_register", 32'(clock_register), 32'(want.clock_register));
        check_field("clock_write_data", 32'(clock_write_data), 32'(want.clock_write_data));
        check_field("clock_latch", 32'(clock_latch), 32'(want.clock_latch));
        check_field("clock_latch_value", 32'(clock_latch_value),
                    32'(want.clock_latch_value));
        check_field("save_request", 32'(save_request), 32'(want.save_request));
        check_field("was_dirty", 32'(was_dirty), 32'(want.was_dirty));
      end
    end
  end

  // Receiver: a requested hold-off first, then random stall bursts.
  always @(negedge clk) begin
    if (rst) begin
      out_ready = 1'b0;
    end else if (hold_cycles > 0) begin
      out_ready = 1'b0;
      hold_cycles--;
    end else if (stall_left > 0) begin
      out_ready = 1'b0;
      stall_left--;
    end else if (idling_on && $urandom_range(0, 5) == 0) begin
      out_ready  = 1'b0;
      stall_left = $urandom_range(1, 16) - 1;
    end else begin
      out_ready = 1'b1;
    end
  end

  // ------------------------------------------------------------------------
  // Stimulus helpers
  // ------------------------------------------------------------------------

  // Offers one access, waits for its transfer and records the expectation.
  task automatic send_access(logic [2:0] kind, logic [14:0] a, logic [7:0] v);
    int gap;
    gap = 0;
    if (idling_on && $urandom_range(0, 4) == 0) gap = $urandom_range(1, 16);
    if (gap > 0) begin
      @(negedge clk);
      in_valid = 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_valid = 1'b1;
    req_type = kind;
    addr     = a;
    data     = v;
    do @(posedge clk); while (!in_ready);
    expected_results.push_back(predict_access(kind, a, v));
  endtask

  // Stops offering and waits until every expected result has arrived.
  task automatic wait_idle();
    @(negedge clk);
    in_valid = 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [17:0] val);
    @(negedge clk);
    cfg_we    = 1'b1;
    cfg_index = idx;
    cfg_data  = val;
    @(posedge clk);
    case (idx)
      CFG_MAPPER_MODEL:   cfg_mapper    = val[2:0];
      CFG_ROM_BANK_COUNT: cfg_rom_banks = val[9:0];
      CFG_RAM_BANK_COUNT: cfg_ram_banks = val[4:0];
      CFG_RAM_SIZE_BYTES: cfg_ram_size  = val;
      CFG_CLOCK_PRESENT:  cfg_clock     = val[0];
      CFG_SAVE_ENABLED:   cfg_save      = val[0];
      default: ;
    endcase
  endtask

  // Writes the whole register set once the block has gone quiet.
  task automatic set_config(logic [2:0] m, logic [9:0] rom_banks, logic [4:0] ram_banks,
                            logic [17:0] ram_size, logic has_clock, logic has_save);
    wait_idle();
    write_reg(CFG_MAPPER_MODEL, m);
    write_reg(CFG_ROM_BANK_COUNT, rom_banks);
    write_reg(CFG_RAM_BANK_COUNT, ram_banks);
    write_reg(CFG_RAM_SIZE_BYTES, ram_size);
    write_reg(CFG_CLOCK_PRESENT, has_clock);
    write_reg(CFG_SAVE_ENABLED, has_save);
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  // Random cartridge, weighted towards the real mappers and the extremes.
  task automatic set_random_config();
    logic [2:0]  m;
    logic [9:0]  rom_banks;
    logic [4:0]  ram_banks;
    logic [17:0] ram_size;
    m = ($urandom_range(0, 7) == 0) ? 3'($urandom_range(5, 7)) : 3'($urandom_range(0, 4));
    case ($urandom_range(0, 5))
      0:       rom_banks = 10'd2;
      1:       rom_banks = 10'd512;
      2:       rom_banks = 10'd0;
      3:       rom_banks = 10'($urandom_range(0, 1023));
      default: rom_banks = 10'($urandom_range(2, 512));
    endcase
    case ($urandom_range(0, 5))
      0:       ram_banks = 5'd0;
      1:       ram_banks = 5'd1;
      2:       ram_banks = 5'd16;
      3:       ram_banks = 5'($urandom_range(0, 31));
      default: ram_banks = 5'($urandom_range(0, 16));
    endcase
    case ($urandom_range(0, 4))
      0:       ram_size = 18'd0;
      1:       ram_size = 18'd2048;
      2:       ram_size = 18'd131072;
      3:       ram_size = 18'($urandom_range(0, 262143));
      default: ram_size = 18'($urandom_range(512, 131072));
    endcase
    set_config(m, rom_banks, ram_banks, ram_size, 1'($urandom_range(0, 1)),
               1'($urandom_range(0, 1)));
  endtask

  // One random access; control writes mostly hit meaningful values.
  task automatic send_random_access();
    int          pick;
    logic [2:0]  kind;
    logic [14:0] a;
    logic [7:0]  v;
    pick = $urandom_range(0, 99);
    a    = 15'($urandom_range(0, 32767));
    v    = 8'($urandom_range(0, 255));
    if (pick < 28) begin
      kind = REQ_ROM_READ;
    end else if (pick < 52) begin
      kind = REQ_CONTROL;
      case ($urandom_range(0, 5))
        0: begin
          a = 15'($urandom_range(0, 16'h1FFF));
          if ($urandom_range(0, 3) != 0) v[3:0] = RAM_ENABLE_KEY;
        end
        1: a = 15'($urandom_range(16'h2000, 16'h2FFF));
        2: a = 15'($urandom_range(16'h3000, 16'h3FFF));
        3: begin
          a = 15'($urandom_range(16'h4000, 16'h5FFF));
          if ($urandom_range(0, 3) != 0) v = 8'($urandom_range(0, 7));
        end
        4: begin
          a = 15'($urandom_range(16'h6000, 16'h7FFF));
          if ($urandom_range(0, 1) != 0) v = 8'($urandom_range(0, 1));
        end
        default: ;
      endcase
    end else if (pick < 72) begin
      kind = REQ_RAM_READ;
    end else if (pick < 94) begin
      kind = REQ_RAM_WRITE;
    end else if (pick < 98) begin
      kind = REQ_SAVE_DONE;
    end else begin
      kind = 3'($urandom_range(5, 7));
    end
    // Keep RAM accesses on a few hot addresses so reads see earlier writes.
    if ((kind == REQ_RAM_READ || kind == REQ_RAM_WRITE) && $urandom_range(0, 1) != 0)
      a[12:0] = ($urandom_range(0, 7) == 0) ? 13'h1FFF : 13'($urandom_range(0, 31));
    send_access(kind, a, v);
  endtask

  // ------------------------------------------------------------------------
  // Tests
  // ------------------------------------------------------------------------

  // Unknown mapper: everything passes through, RAM is absent.
  task automatic test_directed_unmapped();
    set_config(MAP_UNKNOWN, 10'd2, 5'd0, 18'd0, 1'b0, 1'b0);
    send_access(REQ_ROM_READ, 15'h7FFF, 8'h00);
    send_access(REQ_CONTROL, 15'h0000, 8'h0A);
    send_access(REQ_RAM_READ, 15'h7FFF, 8'h00);
    send_access(REQ_UNKNOWN, 15'h7FFF, 8'hFF);
    send_access(REQ_SAVE_DONE, 15'h0000, 8'h00);
  endtask

  // MBC1 with a mirrored partial bank, a bank of zero and a dirty save.
  task automatic test_directed_mbc1();
    set_config(MAP_MBC1, 10'd512, 5'd1, 18'd2048, 1'b0, 1'b1);
    send_access(REQ_CONTROL, 15'h0000, 8'h0A);
    send_access(REQ_CONTROL, 15'h2000, 8'h00);
    send_access(REQ_ROM_READ, 15'h7FFF, 8'h00);
    send_access(REQ_RAM_WRITE, 15'h1FFF, 8'hFF);
    send_access(REQ_RAM_READ, 15'h07FF, 8'h00);
    send_access(REQ_SAVE_DONE, 15'h0000, 8'h00);
  endtask

  // MBC2: locked writes are dropped, then an enabled write and read, high nibble set.
  task automatic test_directed_mbc2();
    set_config(MAP_MBC2, 10'd16, 5'd0, 18'd0, 1'b0, 1'b0);
    send_access(REQ_CONTROL, 15'h0000, 8'h00);
    send_access(REQ_RAM_WRITE, 15'h0100, 8'h33);
    send_access(REQ_CONTROL, 15'h0100, 8'h0A);
    send_access(REQ_RAM_WRITE, 15'h01FF, 8'h05);
    send_access(REQ_RAM_READ, 15'h7FFF, 8'h00);
  endtask

  // MBC3 clock selects and latch, then a clock select with no clock fitted.
  task automatic test_directed_mbc3_clock();
    set_config(MAP_MBC3, 10'd128, 5'd4, 18'd32768, 1'b1, 1'b1);
    send_access(REQ_CONTROL, 15'h0000, 8'h0A);
    send_access(REQ_CONTROL, 15'h4000, 8'h08);
    send_access(REQ_RAM_WRITE, 15'h0010, 8'h5A);
    send_access(REQ_RAM_READ, 15'h0010, 8'h00);
    send_access(REQ_CONTROL, 15'h6000, 8'h01);
    set_config(MAP_MBC3, 10'd128, 5'd4, 18'd32768, 1'b0, 1'b1);
    send_access(REQ_RAM_WRITE, 15'h0010, 8'hA5);
    send_access(REQ_SAVE_DONE, 15'h0000, 8'h00);
  endtask

  // MBC5 with no bank count: the full nine-bit bank, then bank zero.
  task automatic test_directed_mbc5_banks();
    set_config(MAP_MBC5, 10'd0, 5'd16, 18'd131072, 1'b0, 1'b0);
    send_access(REQ_CONTROL, 15'h2000, 8'hFF);
    send_access(REQ_CONTROL, 15'h3000, 8'h01);
    send_access(REQ_ROM_READ, 15'h4000, 8'h00);
    send_access(REQ_CONTROL, 15'h2FFF, 8'h00);
    send_access(REQ_CONTROL, 15'h3FFF, 8'h00);
    send_access(REQ_ROM_READ, 15'h4000, 8'h00);
  endtask

  // Phases of random traffic, each on its own cartridge setting.
  task automatic test_random_configs();
    for (int phase = 0; phase < 26; phase++) begin
      case (phase)
        0:       set_config(MAP_MBC1, 10'd512, 5'd16, 18'd131072, 1'b1, 1'b1);
        1:       set_config(MAP_MBC5, 10'd512, 5'd16, 18'd131072, 1'b1, 1'b1);
        2:       set_config(MAP_MBC3, 10'd2, 5'd0, 18'd0, 1'b1, 1'b0);
        3:       set_config(MAP_MBC1, 10'd2, 5'd1, 18'd0, 1'b0, 1'b1);
        4:       set_config(MAP_MBC2, 10'd2, 5'd0, 18'd0, 1'b0, 1'b1);
        default: set_random_config();
      endcase
      idling_on = ($urandom_range(0, 3) != 0);
      repeat (65) send_random_access();
    end
  endtask

  // The receiver holds off long enough for the block to stall its input.
  task automatic test_backpressure();
    set_config(MAP_MBC5, 10'd512, 5'd16, 18'd131072, 1'b1, 1'b1);
    idling_on = 1'b0;
    @(posedge clk);
    hold_cycles = 200;
    repeat (40) send_random_access();
  endtask

  // Final stretch at full rate on both sides.
  task automatic test_streaming();
    idling_on = 1'b0;
    set_random_config();
    repeat (75) send_random_access();
    set_random_config();
    repeat (75) send_random_access();
  endtask

  // ------------------------------------------------------------------------
  // Sequence
  // ------------------------------------------------------------------------
  initial begin
    for (int i = 0; i < RAM_BYTES; i++) shadow_ram[i] = 8'd0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_directed_unmapped();
    test_directed_mbc1();
    test_directed_mbc2();
    test_directed_mbc3_clock();
    test_directed_mbc5_banks();
    test_random_configs();
    test_backpressure();
    test_streaming();

    // Drain, then keep watching for anything unexpected.
    @(negedge clk);
    in_valid = 1'b0;
    for (int n = 0; n < 5000 && expected_results.size() != 0; n++) @(posedge clk);
    repeat (40) @(posedge clk);
    if (expected_results.size() != 0)
      note_mismatch("results never delivered", 32'd0, 32'(expected_results.size()));

    if (mismatches == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
